### sv/tsq_pkg.sv
// Package with shared types, codes and defaults for the two-stack queue.
`timescale 1ns / 1ps

package tsq_pkg;

  // Default sizes handed to the top level.
  localparam int STACK_DEPTH_DEF = 128;
  localparam int DATA_BITS_DEF   = 32;

  // Fixed port widths.
  localparam int OPCODE_W = 2;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  // Request codes. The fourth code is unused and leaves the queue alone.
  typedef enum logic [OPCODE_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2
  } opcode_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_READ,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;      // latch the incoming request
    logic    push;      // write the word onto the input stack
    logic    move_rd;   // read the input top and shrink the input stack
    logic    move_wr;   // write the moved word onto the output stack
    logic    pop_out;   // read the output top and shrink the output stack
    logic    peek_out;  // read the output top
    logic    peek_in;   // read the input bottom
    logic    set_res;   // load a result with zero data and the given code
    status_t code;
    logic    capture;   // load a result with the word read last cycle
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    opcode_t op;
    logic    in_full;
    logic    in_empty;
    logic    out_full;
    logic    out_empty;
  } dp_sts_t;

endpackage

### sv/tsq_dp.sv
// Datapath of the two-stack queue: both stack memories, fill counters and result register.
`timescale 1ns / 1ps

module tsq_dp #(
  parameter int STACK_DEPTH = tsq_pkg::STACK_DEPTH_DEF,
  parameter int DATA_BITS   = tsq_pkg::DATA_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic        [tsq_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic signed [tsq_pkg::WORD_W-1:0]    in_write_data,
  input  tsq_pkg::dp_cmd_t                     cmd,
  output tsq_pkg::dp_sts_t                     sts,
  output logic signed [tsq_pkg::WORD_W-1:0]    out_read_data,
  output logic        [tsq_pkg::STATUS_W-1:0]  out_status,
  output logic        [tsq_pkg::COUNT_W-1:0]   out_item_count,
  output logic                                 out_is_empty
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  logic [DATA_BITS-1:0] in_mem  [STACK_DEPTH];
  logic [DATA_BITS-1:0] out_mem [STACK_DEPTH];

  tsq_pkg::opcode_t     op_r;
  logic [DATA_BITS-1:0] word_r;
  logic [CNT_W-1:0]     in_fill_r, in_fill_nxt;
  logic [CNT_W-1:0]     out_fill_r, out_fill_nxt;
  logic [DATA_BITS-1:0] in_q_r, out_q_r;
  logic                 src_in_r;
  logic [DATA_BITS-1:0] rd_r;
  tsq_pkg::status_t     st_r;

  logic [63:0]          wd_ext;
  logic [63:0]          rd_ext;
  logic [ADDR_W-1:0]    in_rd_addr;
  logic [ADDR_W-1:0]    out_top_addr;
  logic [CNT_W:0]       total;

  // Request word kept in its low DATA_BITS bits.
  assign wd_ext = {32'd0, in_write_data};

  // Request register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= tsq_pkg::opcode_t'(in_opcode);
      word_r <= wd_ext[DATA_BITS-1:0];
    end
  end

  // Fill counters.
  always_comb begin
    in_fill_nxt  = in_fill_r;
    out_fill_nxt = out_fill_r;
    if (cmd.push)    in_fill_nxt  = in_fill_r + 1'b1;
    if (cmd.move_rd) in_fill_nxt  = in_fill_r - 1'b1;
    if (cmd.move_wr) out_fill_nxt = out_fill_r + 1'b1;
    if (cmd.pop_out) out_fill_nxt = out_fill_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_fill_r  <= '0;
      out_fill_r <= '0;
    end else begin
      in_fill_r  <= in_fill_nxt;
      out_fill_r <= out_fill_nxt;
    end
  end

  // Read addresses: input top or input bottom, and output top.
  assign in_rd_addr   = cmd.peek_in ? '0 : ADDR_W'(in_fill_r - 1'b1);
  assign out_top_addr = ADDR_W'(out_fill_r - 1'b1);

  // Input stack memory.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      in_mem[ADDR_W'(in_fill_r)] <= word_r;
    end
    if (cmd.move_rd || cmd.peek_in) begin
      in_q_r <= in_mem[in_rd_addr];
    end
  end

  // Output stack memory.
  always_ff @(posedge clk) begin
    if (cmd.move_wr) begin
      out_mem[ADDR_W'(out_fill_r)] <= in_q_r;
    end
    if (cmd.pop_out || cmd.peek_out) begin
      out_q_r <= out_mem[out_top_addr];
    end
  end

  // Remember which memory the pending read came from.
  always_ff @(posedge clk) begin
    if (cmd.pop_out || cmd.peek_out || cmd.peek_in) begin
      src_in_r <= cmd.peek_in;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      rd_r <= '0;
      st_r <= cmd.code;
    end else if (cmd.capture) begin
      rd_r <= src_in_r ? in_q_r : out_q_r;
      st_r <= tsq_pkg::ST_OK;
    end
  end

  // Status back to the controller.
  assign sts.op        = op_r;
  assign sts.in_full   = (in_fill_r == CNT_W'(STACK_DEPTH));
  assign sts.in_empty  = (in_fill_r == '0);
  assign sts.out_full  = (out_fill_r == CNT_W'(STACK_DEPTH));
  assign sts.out_empty = (out_fill_r == '0);

  // Result fields; the counts hold still while the result waits.
  assign rd_ext         = 64'(rd_r);
  assign out_read_data  = rd_ext[tsq_pkg::WORD_W-1:0];
  assign out_status     = st_r;
  assign total          = {1'b0, in_fill_r} + {1'b0, out_fill_r};
  assign out_item_count = tsq_pkg::COUNT_W'(total);
  assign out_is_empty   = (total == '0);

endmodule

### sv/tsq_ctrl.sv
// Controller state machine of the two-stack queue.
`timescale 1ns / 1ps

module tsq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  tsq_pkg::dp_sts_t sts,
  output tsq_pkg::dp_cmd_t cmd
);

  tsq_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.code  = tsq_pkg::ST_OK;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      tsq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = tsq_pkg::S_DECODE;
        end
      end
      tsq_pkg::S_DECODE: begin
        case (sts.op)
          tsq_pkg::OP_ENQ: begin
            cmd.set_res = 1'b1;
            if (sts.in_full) begin
              cmd.code = tsq_pkg::ST_FULL;
            end else begin
              cmd.push = 1'b1;
            end
            state_nxt = tsq_pkg::S_RESP;
          end
          tsq_pkg::OP_DEQ: begin
            if (!sts.out_empty) begin
              cmd.pop_out = 1'b1;
              state_nxt   = tsq_pkg::S_READ;
            end else if (!sts.in_empty) begin
              state_nxt = tsq_pkg::S_MOVE_RD;
            end else begin
              cmd.set_res = 1'b1;
              cmd.code    = tsq_pkg::ST_EMPTY;
              state_nxt   = tsq_pkg::S_RESP;
            end
          end
          tsq_pkg::OP_PEEK: begin
            if (!sts.out_empty) begin
              cmd.peek_out = 1'b1;
              state_nxt    = tsq_pkg::S_READ;
            end else if (!sts.in_empty) begin
              cmd.peek_in = 1'b1;
              state_nxt   = tsq_pkg::S_READ;
            end else begin
              cmd.set_res = 1'b1;
              cmd.code    = tsq_pkg::ST_EMPTY;
              state_nxt   = tsq_pkg::S_RESP;
            end
          end
          default: begin
            // Unused code: no change, plain result.
            cmd.set_res = 1'b1;
            state_nxt   = tsq_pkg::S_RESP;
          end
        endcase
      end
      tsq_pkg::S_MOVE_RD: begin
        cmd.move_rd = 1'b1;
        state_nxt   = tsq_pkg::S_MOVE_WR;
      end
      tsq_pkg::S_MOVE_WR: begin
        // Refill done once the input stack runs dry; then decode pops.
        cmd.move_wr = 1'b1;
        state_nxt   = sts.in_empty ? tsq_pkg::S_DECODE : tsq_pkg::S_MOVE_RD;
      end
      tsq_pkg::S_READ: begin
        cmd.capture = 1'b1;
        state_nxt   = tsq_pkg::S_RESP;
      end
      tsq_pkg::S_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = tsq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tsq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### sv/two_stack_queue.sv
// Two-stack queue: first-in first-out queue built from an input and an output stack.
// Path from input beat to result beat: enqueue, empty and unused requests go through decode
// and response; dequeue and peek add a read state. A dequeue that refills the output stack
// moves each entry by one memory read, then one memory write, and then decodes again.
// One request is in flight at a time; the next input beat is taken in the cycle after the result.
// Reset clears the fill counters and controller; the stack memories are not cleared.
`timescale 1ns / 1ps

module two_stack_queue #(
  parameter int STACK_DEPTH = tsq_pkg::STACK_DEPTH_DEF,
  parameter int DATA_BITS   = tsq_pkg::DATA_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic        [tsq_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic signed [tsq_pkg::WORD_W-1:0]    in_write_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tsq_pkg::WORD_W-1:0]    out_read_data,
  output logic        [tsq_pkg::STATUS_W-1:0]  out_status,
  output logic        [tsq_pkg::COUNT_W-1:0]   out_item_count,
  output logic                                 out_is_empty
);

  tsq_pkg::dp_cmd_t cmd;
  tsq_pkg::dp_sts_t sts;

  // Controller.
  tsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath.
  tsq_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_BITS   (DATA_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_opcode      (in_opcode),
    .in_write_data  (in_write_data),
    .cmd            (cmd),
    .sts            (sts),
    .out_read_data  (out_read_data),
    .out_status     (out_status),
    .out_item_count (out_item_count),
    .out_is_empty   (out_is_empty)
  );

  // Only one request is in flight, so the two channels never open together.
  assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("input and result channels open at once");

  // An empty-queue status always comes with both stacks empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == tsq_pkg::ST_EMPTY) |-> out_is_empty)
    else $error("empty status with entries still held");

  // A push never lands on a full input stack.
  assert property (@(posedge clk) disable iff (!rst_n) cmd.push |-> !sts.in_full)
    else $error("push onto full input stack");

  // A refill write never lands on a full output stack.
  assert property (@(posedge clk) disable iff (!rst_n) cmd.move_wr |-> !sts.out_full)
    else $error("refill write onto full output stack");

endmodule

### sim/tb_top.sv
// Self-checking testbench for the two-stack queue: directed and random requests.
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH       = tsq_pkg::STACK_DEPTH_DEF;
  localparam int DATA_BITS   = tsq_pkg::DATA_BITS_DEF;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int DRAIN_WAIT  = 20;
  localparam int RANDOM_ITEMS = 1130;

  // The fourth opcode is not a member of the package enum.
  localparam logic [tsq_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [tsq_pkg::WORD_W-1:0] WORD_MASK =
    {tsq_pkg::WORD_W{1'b1}} >> (tsq_pkg::WORD_W - DATA_BITS);

  typedef struct {
    logic [tsq_pkg::OPCODE_W-1:0] op;
    logic [tsq_pkg::WORD_W-1:0]   word;
  } queue_request_t;

  typedef struct {
    logic [tsq_pkg::WORD_W-1:0]  read_data;
    tsq_pkg::status_t            status;
    logic [tsq_pkg::COUNT_W-1:0] item_count;
    logic                        is_empty;
  } queue_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [tsq_pkg::OPCODE_W-1:0] in_opcode = '0;
  logic signed [tsq_pkg::WORD_W-1:0] in_write_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [tsq_pkg::WORD_W-1:0] out_read_data;
  logic [tsq_pkg::STATUS_W-1:0] out_status;
  logic [tsq_pkg::COUNT_W-1:0] out_item_count;
  logic out_is_empty;

  // Shadow copy of the two stacks.
  logic [tsq_pkg::WORD_W-1:0] in_stack [DEPTH];
  logic [tsq_pkg::WORD_W-1:0] out_stack [DEPTH];
  int in_depth = 0;
  int out_depth = 0;

  queue_request_t requests_pending [$];
  queue_reply_t   replies_due [$];
  queue_reply_t   reply_now;
  queue_request_t req_now;

  int  fail_count = 0;
  int  cycle_count = 0;
  bit  in_beat = 1'b0;
  bit  next_valid;
  int  burst_left = 0;
  int  gap_left = 0;
  int  stall_span = 0;
  int  stall_mode = 0;

  two_stack_queue #(
    .STACK_DEPTH(DEPTH),
    .DATA_BITS  (DATA_BITS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .out_status    (out_status),
    .out_item_count(out_item_count),
    .out_is_empty  (out_is_empty)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run the request through the shadow stacks and queue the reply it must give.
  task automatic apply_request(input logic [tsq_pkg::OPCODE_W-1:0] op,
                               input logic [tsq_pkg::WORD_W-1:0] word);
    queue_reply_t r;
    int total;
    r.read_data = '0;
    r.status = tsq_pkg::ST_OK;
    case (op)
      tsq_pkg::OP_ENQ: begin
        if (in_depth >= DEPTH) begin
          r.status = tsq_pkg::ST_FULL;
        end else begin
          in_stack[in_depth] = word & WORD_MASK;
          in_depth++;
        end
      end
      tsq_pkg::OP_DEQ: begin
        // An empty output stack takes the whole input stack, top first.
        if (out_depth == 0) begin
          while (in_depth > 0 && out_depth < DEPTH) begin
            in_depth--;
            out_stack[out_depth] = in_stack[in_depth];
            out_depth++;
          end
        end
        if (out_depth == 0) begin
          r.status = tsq_pkg::ST_EMPTY;
        end else begin
          out_depth--;
          r.read_data = out_stack[out_depth];
        end
      end
      tsq_pkg::OP_PEEK: begin
        // The front is the output top, or the input bottom when the output is empty.
        if (out_depth > 0) begin
          r.read_data = out_stack[out_depth-1];
        end else if (in_depth > 0) begin
          r.read_data = in_stack[0];
        end else begin
          r.status = tsq_pkg::ST_EMPTY;
        end
      end
      default: begin
      end
    endcase
    total = in_depth + out_depth;
    r.item_count = tsq_pkg::COUNT_W'(total);
    r.is_empty = (total == 0);
    replies_due.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [tsq_pkg::WORD_W-1:0] exp_val,
                             input logic [tsq_pkg::WORD_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      fail_count++;
    end
  endtask

  task automatic add_request(input logic [tsq_pkg::OPCODE_W-1:0] op,
                             input logic [tsq_pkg::WORD_W-1:0] word);
    queue_request_t q;
    q.op = op;
    q.word = word;
    requests_pending.push_back(q);
  endtask

  // Result beats are checked before a new input beat is predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual data %0h status %0d",
                   $time, out_read_data, out_status);
          fail_count++;
        end else begin
          reply_now = replies_due.pop_front();
          check_field("read_data", reply_now.read_data, out_read_data);
          check_field("status", tsq_pkg::WORD_W'(reply_now.status),
                      tsq_pkg::WORD_W'(out_status));
          check_field("item_count", tsq_pkg::WORD_W'(reply_now.item_count),
                      tsq_pkg::WORD_W'(out_item_count));
          check_field("is_empty", tsq_pkg::WORD_W'(reply_now.is_empty),
                      tsq_pkg::WORD_W'(out_is_empty));
        end
      end
      in_beat = (in_valid && in_ready === 1'b1);
      if (in_beat) begin
        apply_request(in_opcode, in_write_data);
      end
    end else begin
      in_beat = 1'b0;
    end
  end

  // Sender: bursts of requests separated by random gaps.
  always @(negedge clk) begin
    if (rst_n) begin
      next_valid = in_valid && !in_beat;
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (requests_pending.size() > 0) begin
          req_now = requests_pending.pop_front();
          in_opcode <= req_now.op;
          in_write_data <= req_now.word;
          next_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // Receiver: switches between always ready, random stalls and long stalls.
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_span = $urandom_range(5, 60);
      stall_mode = $urandom_range(0, 2);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int added;
    int phase;
    int len;
    int n;
    logic [tsq_pkg::OPCODE_W-1:0] op;

    // Directed part: empty queue, word extremes, both peek sources, refills.
    add_request(tsq_pkg::OP_DEQ, 32'h1234_5678);
    add_request(tsq_pkg::OP_PEEK, 32'h0);
    add_request(OP_UNUSED, 32'hFFFF_FFFF);
    add_request(tsq_pkg::OP_ENQ, 32'h8000_0000);
    add_request(tsq_pkg::OP_PEEK, 32'h0);
    add_request(tsq_pkg::OP_ENQ, 32'h7FFF_FFFF);
    add_request(tsq_pkg::OP_ENQ, 32'h0000_0000);
    add_request(tsq_pkg::OP_ENQ, 32'hFFFF_FFFF);
    add_request(tsq_pkg::OP_PEEK, 32'hDEAD_BEEF);
    add_request(tsq_pkg::OP_DEQ, 32'h0);
    add_request(tsq_pkg::OP_PEEK, 32'h0);
    add_request(tsq_pkg::OP_ENQ, 32'hAAAA_AAAA);
    add_request(tsq_pkg::OP_PEEK, 32'h0);
    add_request(OP_UNUSED, 32'h5555_5555);
    add_request(tsq_pkg::OP_DEQ, 32'h0);
    add_request(tsq_pkg::OP_DEQ, 32'h0);
    add_request(tsq_pkg::OP_DEQ, 32'h0);
    add_request(tsq_pkg::OP_PEEK, 32'h0);
    add_request(tsq_pkg::OP_DEQ, 32'h0);
    add_request(tsq_pkg::OP_DEQ, 32'h0);
    add_request(tsq_pkg::OP_ENQ, 32'h5555_5555);
    add_request(tsq_pkg::OP_DEQ, 32'h0);

    // Random part in phases; the first one overflows the input stack twice,
    // the second time while the output stack still has room.
    added = 0;
    phase = 8;
    while (added < RANDOM_ITEMS) begin
      case (phase)
        0, 1, 2, 3: begin
          len = $urandom_range(10, 60);
          for (n = 0; n < len; n++) begin
            case ($urandom_range(0, 19))
              0, 1, 2, 3, 4, 5, 6, 7, 8: op = tsq_pkg::OP_ENQ;
              9, 10, 11, 12, 13, 14, 15: op = tsq_pkg::OP_DEQ;
              16, 17, 18: op = tsq_pkg::OP_PEEK;
              default: op = OP_UNUSED;
            endcase
            add_request(op, $urandom());
          end
        end
        4, 5: begin
          len = $urandom_range(20, 140);
          for (n = 0; n < len; n++) begin
            add_request(($urandom_range(0, 9) == 0) ? tsq_pkg::OP_PEEK : tsq_pkg::OP_ENQ,
                        $urandom());
          end
        end
        6, 7: begin
          len = $urandom_range(10, 150);
          for (n = 0; n < len; n++) begin
            add_request(($urandom_range(0, 5) == 0) ? tsq_pkg::OP_PEEK : tsq_pkg::OP_DEQ,
                        $urandom());
          end
        end
        8: begin
          len = DEPTH + 2;
          for (n = 0; n < len; n++) add_request(tsq_pkg::OP_ENQ, $urandom());
          add_request(tsq_pkg::OP_DEQ, $urandom());
          for (n = 0; n < len; n++) add_request(tsq_pkg::OP_ENQ, $urandom());
          add_request(tsq_pkg::OP_PEEK, $urandom());
          len = 2 * len + 2;
        end
        default: begin
          len = $urandom_range(5, 30);
          for (n = 0; n < len; n++) begin
            add_request(tsq_pkg::OPCODE_W'($urandom_range(0, 3)), $urandom());
          end
        end
      endcase
      added += len;
      phase = $urandom_range(0, 9);
    end

    // Hold reset, then release it at a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every request to be taken and every reply to arrive.
    while (requests_pending.size() != 0 || in_valid || replies_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
sv/tsq_pkg.sv
sv/tsq_dp.sv
sv/tsq_ctrl.sv
sv/two_stack_queue.sv
sim/tb_top.sv
